// ===== src/usrf_pkg.sv =====
// ----------------------------------------------------------------------------
// usrf_pkg
// Shared types and codes for the URL substring rule filter.
// ----------------------------------------------------------------------------
package usrf_pkg;

  localparam logic [1:0] REQ_PAT  = 2'd0;
  localparam logic [1:0] REQ_ATTR = 2'd1;
  localparam logic [1:0] REQ_URL  = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_EXT  = 2'd1;
  localparam logic [1:0] ACT_DOC  = 2'd2;
  localparam logic [1:0] ACT_RSVD = 2'd3;

  localparam logic [2:0] DOC_COUNT = 3'd5;

  localparam logic [2:0] V_NOT_OURS = 3'd0;
  localparam logic [2:0] V_NO_MATCH = 3'd1;
  localparam logic [2:0] V_REWRITE  = 3'd2;
  localparam logic [2:0] V_BOUNCE   = 3'd3;
  localparam logic [2:0] V_DOC      = 3'd4;
  localparam logic [2:0] V_TEMPLATE = 3'd5;
  localparam logic [2:0] V_BAN      = 3'd6;

  localparam logic [2:0] CFG_RULES    = 3'd0;
  localparam logic [2:0] CFG_BOUNCE   = 3'd1;
  localparam logic [2:0] CFG_TEMPLATE = 3'd2;
  localparam logic [2:0] CFG_PORTS    = 3'd3;
  localparam logic [2:0] CFG_PORT0    = 3'd4;

  // byte handed along the cell row
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } byte_t;

  // table write handed along the cell row
  typedef struct packed {
    logic       pat_we;
    logic       attr_we;
    logic [7:0] slot;
    logic [6:0] pos;
    logic [7:0] ch;
    logic [6:0] plen;
    logic [1:0] act;
    logic [2:0] doc;
  } wr_t;

  // report a cell gives to its token stage at URL end
  typedef struct packed {
    logic       hit;
    logic [1:0] act;
    logic [2:0] doc;
  } rep_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) return c - 8'd32;
    return c;
  endfunction

endpackage

// ===== src/usrf_cell.sv =====
// ----------------------------------------------------------------------------
// usrf_cell
// One rule: pattern store, shift-and match vector and sticky hit flag.
// Forwards the byte and any table write, registered, to the next cell.
// ----------------------------------------------------------------------------
module usrf_cell #(
  parameter int PB  = 32,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  usrf_pkg::wr_t   wr_in,
  output usrf_pkg::wr_t   wr_out,
  input  usrf_pkg::byte_t bin,
  output usrf_pkg::byte_t bout,
  output usrf_pkg::rep_t  rep
);
  import usrf_pkg::*;

  localparam int LW = $clog2(PB + 1);
  localparam int PW = $clog2(PB > 1 ? PB : 2);

  logic [7:0]    pat [PB];
  logic [6:0]    plen;
  logic [1:0]    act;
  logic [2:0]    doc;
  logic [PB-1:0] vec;
  logic          hit;
  logic [PB-1:0] eq;
  logic [PB-1:0] vec_next;
  logic [LW-1:0] len;
  logic          hit_next;
  logic          my_slot;

  assign my_slot = (wr_in.slot == 8'(IDX));

  always_comb begin
    if (plen > 7'(PB)) len = LW'(PB);
    else len = LW'(plen);
    for (int j = 0; j < PB; j++) begin
      eq[j] = (LW'(j) < len) && (fold(pat[j]) == fold(bin.ch));
    end
    vec_next = ((vec << 1) | PB'(1)) & eq;
    if (len == '0) begin
      vec_next = '0;
      hit_next = 1'b1;
    end else begin
      hit_next = hit | vec_next[PW'(len - LW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_in.pat_we && my_slot && wr_in.pos < 7'(PB)) begin
      pat[wr_in.pos[PW-1:0]] <= wr_in.ch;
    end
    if (wr_in.attr_we && my_slot) begin
      plen <= wr_in.plen;
      act  <= wr_in.act;
      doc  <= wr_in.doc;
    end
    bout   <= rst ? '0 : bin;
    wr_out <= rst ? '0 : wr_in;
    if (rst) begin
      vec <= '0;
      hit <= 1'b0;
    end else if (bin.valid) begin
      if (bin.last) begin
        vec <= '0;
        hit <= 1'b0;
      end else begin
        vec <= vec_next;
        hit <= hit_next;
      end
    end
  end

  assign rep.hit = hit_next;
  assign rep.act = act;
  assign rep.doc = doc;
endmodule

// ===== src/url_substring_rule_filter.sv =====
// ----------------------------------------------------------------------------
// url_substring_rule_filter
// Case-insensitive multi-pattern substring filter with port filter.
// ----------------------------------------------------------------------------
// Rules sit in a row of RULE_COUNT cells; table writes and URL bytes are taken
// one per cycle while in_stall is low and walk the row one cell per cycle, so
// every cell sees them in arrival order. A URL's last byte carries the first-hit
// choice down the row through the token registers; out_valid is registered from
// the last of them, and the input stalls from the edge that accepts the last
// byte until the verdict is taken.
module url_substring_rule_filter #(
  parameter int RULE_COUNT    = 16,
  parameter int PATTERN_BYTES = 32,
  parameter int PORT_ENTRIES  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  rule_slot,
  input  logic [4:0]  char_position,
  input  logic [7:0]  char_value,
  input  logic [5:0]  pattern_length,
  input  logic [1:0]  rule_action,
  input  logic [2:0]  document_index,
  input  logic        url_end,
  input  logic [15:0] local_port,
  input  logic [31:0] local_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic [3:0]  matched_rule,
  output logic [2:0]  matched_document
);
  import usrf_pkg::*;

  localparam int N = RULE_COUNT;

  logic [4:0]  rules_in_use;
  logic        bounce_mode;
  logic        template_loaded;
  logic [2:0]  ports_in_use;
  logic [47:0] port_entry [PORT_ENTRIES];

  logic       busy;
  logic       accept;
  logic [8:0] n_eff;
  logic       port_ok;
  logic [2:0] np;
  byte_t      chain [N+1];
  wr_t        wr_chain [N+1];
  wr_t        wr_head;
  rep_t       rep [N];

  logic       s_run [N];
  logic       s_done [N];
  logic [2:0] s_v [N];
  logic [3:0] s_r [N];
  logic [2:0] s_d [N];
  logic       o_done [N];
  logic [2:0] o_v [N];
  logic [3:0] o_r [N];
  logic [2:0] o_d [N];
  logic       t_run [N];
  logic       t_done [N];
  logic [2:0] t_v [N];
  logic [3:0] t_r [N];
  logic [2:0] t_d [N];

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
      bounce_mode <= 1'b0;
      template_loaded <= 1'b0;
      ports_in_use <= '0;
      for (int i = 0; i < PORT_ENTRIES; i++) port_entry[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULES:    rules_in_use <= cfg_data[4:0];
        CFG_BOUNCE:   bounce_mode <= cfg_data[0];
        CFG_TEMPLATE: template_loaded <= cfg_data[0];
        CFG_PORTS:    ports_in_use <= cfg_data[2:0];
        default: begin
          for (int i = 0; i < PORT_ENTRIES; i++) begin
            if (cfg_index == CFG_PORT0 + 3'(i)) port_entry[i] <= cfg_data;
          end
        end
      endcase
    end
  end

  always_comb begin
    np = (ports_in_use > 3'(PORT_ENTRIES)) ? 3'(PORT_ENTRIES) : ports_in_use;
    port_ok = (np == '0);
    for (int i = 0; i < PORT_ENTRIES; i++) begin
      if (3'(i) < np && port_entry[i][47:32] == local_port &&
          (port_entry[i][31:0] == '0 || port_entry[i][31:0] == local_address))
        port_ok = 1'b1;
    end
    n_eff = (9'(rules_in_use) > 9'(N)) ? 9'(N) : 9'(rules_in_use);
  end

  assign chain[0].valid = accept && req_type == REQ_URL;
  assign chain[0].ch    = char_value;
  assign chain[0].last  = url_end;

  always_comb begin
    wr_head.pat_we  = accept && req_type == REQ_PAT;
    wr_head.attr_we = accept && req_type == REQ_ATTR;
    wr_head.slot    = 8'(rule_slot);
    wr_head.pos     = 7'(char_position);
    wr_head.ch      = char_value;
    wr_head.plen    = 7'(pattern_length);
    wr_head.act     = (rule_action == ACT_RSVD) ? ACT_NONE : rule_action;
    wr_head.doc     = document_index;
  end
  assign wr_chain[0] = wr_head;

  for (genvar r = 0; r < N; r++) begin : g_cell
    usrf_cell #(.PB(PATTERN_BYTES), .IDX(r)) u_cell (
      .clk(clk), .rst(rst), .wr_in(wr_chain[r]), .wr_out(wr_chain[r+1]),
      .bin(chain[r]), .bout(chain[r+1]), .rep(rep[r])
    );
  end

  // verdict token travels with the last byte
  assign s_run[0]  = chain[0].valid && chain[0].last;
  assign s_done[0] = !port_ok;
  assign s_v[0]    = port_ok ? V_NO_MATCH : V_NOT_OURS;
  assign s_r[0]    = '0;
  assign s_d[0]    = '0;

  for (genvar r = 1; r < N; r++) begin : g_link
    assign s_run[r]  = t_run[r-1];
    assign s_done[r] = t_done[r-1];
    assign s_v[r]    = t_v[r-1];
    assign s_r[r]    = t_r[r-1];
    assign s_d[r]    = t_d[r-1];
  end

  // stage r evaluates cell r when the last byte is at that cell
  for (genvar r = 0; r < N; r++) begin : g_tok
    logic       take;
    logic       l_done;
    logic [2:0] l_v, l_d;
    logic [3:0] l_r;
    always_comb begin
      take   = !s_done[r] && rep[r].hit && 9'(r) < n_eff;
      l_done = s_done[r] | take;
      l_r    = take ? 4'(r) : s_r[r];
      l_v    = s_v[r];
      l_d    = s_d[r];
      if (take) begin
        l_d = '0;
        if (rep[r].act == ACT_DOC && rep[r].doc < DOC_COUNT) begin
          l_v = V_DOC;
          l_d = rep[r].doc;
        end else if (rep[r].act == ACT_EXT || rep[r].act == ACT_DOC) begin
          l_v = bounce_mode ? V_BOUNCE : V_REWRITE;
        end else begin
          l_v = template_loaded ? V_TEMPLATE : V_BAN;
        end
      end
    end
    assign o_done[r] = l_done;
    assign o_v[r]    = l_v;
    assign o_r[r]    = l_r;
    assign o_d[r]    = l_d;
  end

  // token registers between stages
  always_ff @(posedge clk) begin
    for (int r = 0; r < N; r++) begin
      t_done[r] <= o_done[r];
      t_v[r]    <= o_v[r];
      t_r[r]    <= o_r[r];
      t_d[r]    <= o_d[r];
      t_run[r]  <= rst ? 1'b0 : s_run[r];
    end
  end

  // busy from acceptance of a URL end until its result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && req_type == REQ_URL && url_end) busy <= 1'b1;
      else if (out_valid && !out_stall) busy <= 1'b0;
      if (t_run[N-1]) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (t_run[N-1]) begin
      verdict <= t_v[N-1];
      matched_rule <= t_r[N-1];
      matched_document <= t_d[N-1];
    end
  end
endmodule

// ===== src/usrf_checker.sv =====
// ----------------------------------------------------------------------------
// usrf_checker
// Port-level checks for the URL substring rule filter.
// ----------------------------------------------------------------------------
module usrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] verdict,
  input logic [3:0] matched_rule,
  input logic [2:0] matched_document
);
  import usrf_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("request withdrawn while stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict) &&
      $stable(matched_rule) && $stable(matched_document))
    else $error("result dropped while stalled");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict <= V_BAN)
    else $error("verdict out of range");
  a_doc: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != V_DOC |-> matched_document == 3'd0)
    else $error("document without internal verdict");
  a_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == V_NOT_OURS || verdict == V_NO_MATCH) |-> matched_rule == 4'd0)
    else $error("rule index without match");
endmodule

bind url_substring_rule_filter usrf_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .verdict(verdict),
  .matched_rule(matched_rule), .matched_document(matched_document)
);

// ===== tb/sv/url_substring_rule_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_substring_rule_filter_tb
// Self-checking bench: loads the rule table, runs a directed table of
// requests, then random URL streams and rule rewrites over several register
// settings, checking every verdict against the directed table or an in-bench match predictor.
// ----------------------------------------------------------------------------
module url_substring_rule_filter_tb;
  import usrf_pkg::*;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         WDOG_LIMIT  = 5000;
  localparam int         SETTLE      = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [4:0]  pos;
    logic [7:0]  ch;
    logic [5:0]  plen;
    logic [1:0]  act;
    logic [2:0]  doc;
    logic        last;
    logic [15:0] port;
    logic [31:0] addr;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  typedef struct packed {
    logic [2:0] verdict;
    logic [3:0] rule;
    logic [2:0] doc;
  } res_t;

  typedef struct packed {
    req_t rq;
    logic typed;
    res_t res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  verdict;
  logic [3:0]  matched_rule;
  logic [2:0]  matched_document;
  req_t        drv_req;
  logic        drv_typed;
  res_t        drv_exp;

  // predictor state
  logic [7:0]  rule_pat [16][32];
  logic [5:0]  rule_len [16];
  logic [1:0]  rule_act [16];
  logic [2:0]  rule_doc [16];
  logic [31:0] prefix_vec [16];
  logic [15:0] rule_hit;
  logic [4:0]  cfg_rules;
  logic        cfg_bounce;
  logic        cfg_tmpl;
  logic [2:0]  cfg_ports;
  logic [47:0] cfg_port [4];

  res_t verdict_q[$];
  int   errors, items_acc, results_seen, wdog, hold_left, sent_items;
  int   verdict_seen [8];
  bit   idle_on, stall_on, hold_go, hold_used;

  url_substring_rule_filter DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(drv_req.kind), .rule_slot(drv_req.slot), .char_position(drv_req.pos),
    .char_value(drv_req.ch), .pattern_length(drv_req.plen), .rule_action(drv_req.act),
    .document_index(drv_req.doc), .url_end(drv_req.last), .local_port(drv_req.port),
    .local_address(drv_req.addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .verdict(verdict), .matched_rule(matched_rule), .matched_document(matched_document)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic logic [7:0] upcase(logic [7:0] c);
    if (c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  function automatic bit port_allowed(logic [15:0] p, logic [31:0] a);
    int n;
    n = (cfg_ports > 4) ? 4 : cfg_ports;
    if (n == 0) return 1'b1;
    for (int i = 0; i < n; i++)
      if (cfg_port[i][47:32] == p && (cfg_port[i][31:0] == 0 || cfg_port[i][31:0] == a))
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict(req_t r, output bit has_res, output res_t res);
    int          len, n;
    logic [31:0] eq, nv;
    logic [7:0]  fc;
    has_res = 1'b0;
    res = '0;
    case (r.kind)
      REQ_PAT: rule_pat[r.slot][r.pos] = r.ch;
      REQ_ATTR: begin
        rule_len[r.slot] = r.plen;
        rule_act[r.slot] = (r.act == ACT_RSVD) ? ACT_NONE : r.act;
        rule_doc[r.slot] = r.doc;
      end
      REQ_URL: begin
        fc = upcase(r.ch);
        for (int k = 0; k < 16; k++) begin
          len = (rule_len[k] > 32) ? 32 : rule_len[k];
          if (len == 0) begin
            rule_hit[k] = 1'b1;
            prefix_vec[k] = '0;
          end else begin
            eq = '0;
            for (int j = 0; j < len; j++)
              if (upcase(rule_pat[k][j]) == fc) eq[j] = 1'b1;
            nv = ((prefix_vec[k] << 1) | 32'd1) & eq;
            prefix_vec[k] = nv;
            if (nv[len-1]) rule_hit[k] = 1'b1;
          end
        end
        if (r.last) begin
          has_res = 1'b1;
          res.verdict = V_NO_MATCH;
          n = (cfg_rules > 16) ? 16 : cfg_rules;
          if (!port_allowed(r.port, r.addr)) begin
            res.verdict = V_NOT_OURS;
          end else begin
            for (int k = 0; k < n; k++) begin
              if (rule_hit[k]) begin
                res.rule = 4'(k);
                if (rule_act[k] == ACT_DOC && rule_doc[k] < DOC_COUNT) begin
                  res.verdict = V_DOC;
                  res.doc = rule_doc[k];
                end else if (rule_act[k] == ACT_EXT || rule_act[k] == ACT_DOC) begin
                  res.verdict = cfg_bounce ? V_BOUNCE : V_REWRITE;
                end else begin
                  res.verdict = cfg_tmpl ? V_TEMPLATE : V_BAN;
                end
                break;
              end
            end
          end
          for (int k = 0; k < 16; k++) prefix_vec[k] = '0;
          rule_hit = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // sampled at the falling edge: everything driven at the rising edge is stable
  always @(negedge clk) begin
    bit   has, moved;
    res_t p, e;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        items_acc++;
        predict(drv_req, has, p);
        if (has) verdict_q.push_back(drv_typed ? drv_exp : p);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        verdict_seen[verdict]++;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected verdict %0d rule %0d doc %0d",
                                     verdict, matched_rule, matched_document);
        end else begin
          e = verdict_q.pop_front();
          if (e.verdict !== verdict || e.rule !== matched_rule || e.doc !== matched_document) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp v%0d r%0d d%0d got v%0d r%0d d%0d", e.verdict, e.rule,
                       e.doc, verdict, matched_rule, matched_document);
          end
        end
      end
      wdog = moved ? 0 : wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", WDOG_LIMIT);
        $display("url_substring_rule_filter_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= stall_on && ($urandom_range(99) < 35);
      end
    end
  end

  task automatic push_req(row_t row);
    bit took;
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    drv_req   <= row.rq;
    drv_typed <= row.typed;
    drv_exp   <= row.res;
    if (row.rq.kind != REQ_IGNORED) sent_items++;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send(req_t r);
    push_req('{rq: r, typed: 1'b0, res: '0});
  endtask

  task automatic set_reg(logic [2:0] idx, logic [47:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      CFG_RULES:    cfg_rules  = v[4:0];
      CFG_BOUNCE:   cfg_bounce = v[0];
      CFG_TEMPLATE: cfg_tmpl   = v[0];
      CFG_PORTS:    cfg_ports  = v[2:0];
      default:      cfg_port[idx - CFG_PORT0] = v;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic req_t url_b(logic [7:0] c, logic last, logic [15:0] p = 16'd0,
                                 logic [31:0] a = 32'd0);
    req_t r;
    r = '0;
    r.kind = REQ_URL; r.ch = c; r.last = last; r.port = p; r.addr = a;
    return r;
  endfunction

  function automatic req_t pat_w(logic [3:0] s, logic [4:0] pos, logic [7:0] c);
    req_t r;
    r = '0;
    r.kind = REQ_PAT; r.slot = s; r.pos = pos; r.ch = c;
    return r;
  endfunction

  function automatic req_t attr_w(logic [3:0] s, logic [5:0] l, logic [1:0] act,
                                  logic [2:0] d);
    req_t r;
    r = '0;
    r.kind = REQ_ATTR; r.slot = s; r.plen = l; r.act = act; r.doc = d;
    return r;
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] abc [7] = '{"a", "b", "c", "A", "B", "/", "."};
    if ($urandom_range(99) < 8) return 8'($urandom_range(255));
    return abc[$urandom_range(6)];
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
      return $urandom_range(1) ? (c ^ 8'h20) : c;
    return c;
  endfunction

  task automatic random_url();
    int          n, s, len, emb;
    logic [15:0] p;
    logic [31:0] a;
    logic [7:0]  bytes [$];
    int          i;
    n = $urandom_range(1, 10);
    for (i = 0; i < n; i++) bytes.push_back(pick_char());
    if ($urandom_range(99) < 40) begin
      s = $urandom_range(15);
      len = (rule_len[s] > 32) ? 32 : rule_len[s];
      emb = $urandom_range(0, bytes.size());
      for (i = len - 1; i >= 0; i--) bytes.insert(emb, flip_case(rule_pat[s][i]));
    end
    if ($urandom_range(99) < 60) begin
      s = $urandom_range(3);
      p = cfg_port[s][47:32];
      a = $urandom_range(1) ? cfg_port[s][31:0] : $urandom;
    end else begin
      p = 16'($urandom);
      a = $urandom;
    end
    for (i = 0; i < bytes.size(); i++)
      send(url_b(bytes[i], 1'b0, 16'($urandom), $urandom));
    // port and address only matter on the last byte
    send(url_b(pick_char(), 1'b1, p, a));
  endtask

  task automatic random_rule();
    int s, len;
    s = $urandom_range(15);
    len = ($urandom_range(99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 63);
    for (int j = 0; j < ((len > 32) ? 32 : len); j++)
      send(pat_w(4'(s), 5'(j), pick_char()));
    send(attr_w(4'(s), 6'(len), 2'($urandom_range(3)), 3'($urandom_range(7))));
  endtask

  task automatic random_noise();
    req_t r;
    r = REQ_W'({$urandom, $urandom, $urandom});
    if ($urandom_range(1)) r.kind = REQ_IGNORED;
    else r.kind = REQ_PAT;
    send(r);
  endtask

  task automatic configure(int ph);
    int          rules_sel [6] = '{16, 0, 31, 5, 16, 1};
    int          ports_sel [6] = '{0, 4, 7, 1, 2, 3};
    logic [15:0] pnum [4] = '{16'd80, 16'd8080, 16'hFFFF, 16'd0};
    set_reg(CFG_RULES, 48'(rules_sel[ph]));
    set_reg(CFG_BOUNCE, 48'(ph[0]));
    set_reg(CFG_TEMPLATE, 48'(ph[1]));
    set_reg(CFG_PORTS, 48'(ports_sel[ph]));
    for (int i = 0; i < 4; i++) begin
      if (ph == 3) set_reg(3'(CFG_PORT0 + i), 48'hFFFF_FFFF_FFFF);
      else set_reg(3'(CFG_PORT0 + i),
                   {pnum[$urandom_range(3)], $urandom_range(1) ? 32'd0 : 32'($urandom)});
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    row_t dir_rows [$];
    int   ph, start;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; drv_req = '0; drv_typed = 1'b0; drv_exp = '0;
    errors = 0; items_acc = 0; results_seen = 0; wdog = 0; sent_items = 0;
    idle_on = 1'b0; stall_on = 1'b0; hold_go = 1'b0;
    foreach (verdict_seen[i]) verdict_seen[i] = 0;
    foreach (prefix_vec[i]) prefix_vec[i] = '0;
    rule_hit = '0; cfg_rules = '0; cfg_bounce = 1'b0; cfg_tmpl = 1'b0; cfg_ports = '0;
    foreach (cfg_port[i]) cfg_port[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every table entry gets written before any URL byte is fed
    for (int s = 0; s < 16; s++) begin
      send(attr_w(4'(s), 6'd0, ACT_NONE, 3'd0));
      for (int j = 0; j < 32; j++) send(pat_w(4'(s), 5'(j), 8'h00));
    end
    drain();
    set_reg(CFG_RULES, 48'd16);
    set_reg(CFG_BOUNCE, 48'd0);
    set_reg(CFG_TEMPLATE, 48'd0);
    set_reg(CFG_PORTS, 48'd0);
    cfg_we <= 1'b0;
    @(posedge clk);

    dir_rows = '{
      '{url_b(8'h00, 1'b1), 1'b1, '{V_BAN, 4'd0, 3'd0}},
      '{attr_w(4'd0, 6'd3, ACT_EXT, 3'd0), 1'b0, '0},
      '{pat_w(4'd0, 5'd0, "a"), 1'b0, '0},
      '{pat_w(4'd0, 5'd1, "B"), 1'b0, '0},
      '{pat_w(4'd0, 5'd2, "c"), 1'b0, '0},
      '{url_b("x", 1'b0), 1'b0, '0},
      '{url_b("A", 1'b0), 1'b0, '0},
      '{url_b("b", 1'b0), 1'b0, '0},
      '{url_b("C", 1'b1, 16'hFFFF, 32'hFFFF_FFFF), 1'b1, '{V_REWRITE, 4'd0, 3'd0}},
      '{url_b("z", 1'b1), 1'b1, '{V_BAN, 4'd1, 3'd0}},
      '{attr_w(4'd1, 6'd63, ACT_RSVD, 3'd7), 1'b0, '0},
      '{attr_w(4'd2, 6'd0, ACT_DOC, 3'd4), 1'b0, '0},
      '{attr_w(4'd0, 6'd3, ACT_DOC, 3'd7), 1'b0, '0},
      '{url_b("q", 1'b1), 1'b1, '{V_DOC, 4'd2, 3'd4}},
      '{url_b("a", 1'b0), 1'b0, '0},
      '{url_b("b", 1'b0), 1'b0, '0},
      '{url_b("c", 1'b1), 1'b1, '{V_REWRITE, 4'd0, 3'd0}},
      '{{REQ_IGNORED, {(REQ_W - 2){1'b1}}}, 1'b0, '0},
      '{pat_w(4'd15, 5'd31, 8'hFF), 1'b0, '0},
      '{url_b(8'hFF, 1'b1), 1'b0, '0},
      '{attr_w(4'd1, 6'd32, ACT_NONE, 3'd0), 1'b0, '0},
      '{url_b(8'h7F, 1'b1, 16'd0, 32'd0), 1'b0, '0}
    };
    foreach (dir_rows[i]) push_req(dir_rows[i]);

    for (ph = 0; ph < 6; ph++) begin
      drain();
      configure(ph);
      idle_on  = (ph != 0);
      stall_on = (ph != 0);
      if (ph == 2) hold_go = 1'b1;
      start = sent_items;
      while (sent_items - start < 175) begin
        case ($urandom_range(9))
          0, 1:    random_rule();
          2:       random_noise();
          default: random_url();
        endcase
      end
    end
    drain();

    $display("%0d requests accepted, %0d verdicts checked over 6 register settings",
             items_acc, results_seen);
    $display("verdicts seen: not-ours %0d none %0d rewrite %0d bounce %0d doc %0d tmpl %0d ban %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4], verdict_seen[5], verdict_seen[6]);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("url_substring_rule_filter_tb: clean");
    end else begin
      $display("%0d mismatches, %0d verdicts outstanding", errors, verdict_q.size());
      $display("url_substring_rule_filter_tb: errors");
    end
    $finish;
  end

endmodule
